### rtl/kpd_pkg.sv
package kpd_pkg;

	localparam int unsigned CFG_W  = 16;
	localparam int unsigned CODE_W = 6;
	localparam int unsigned KIND_W = 2;
	localparam int unsigned ROW_W  = 2;
	localparam int unsigned COL_W  = 2;
	localparam int unsigned ROWS   = 4;
	localparam int unsigned COLS   = 3;
	localparam int unsigned IDX_W  = 2;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_ACK  = 1'b1;

	localparam logic [IDX_W-1:0] REG_SCAN_PERIOD   = 2'd0;
	localparam logic [IDX_W-1:0] REG_DEBOUNCE_TIME = 2'd1;
	localparam logic [IDX_W-1:0] REG_RESET_HOLD    = 2'd2;
	localparam logic [IDX_W-1:0] REG_MENU_HOLD     = 2'd3;

	localparam logic [CFG_W-1:0] SCAN_PERIOD_RST   = 16'd40;
	localparam logic [CFG_W-1:0] DEBOUNCE_TIME_RST = 16'd35;
	localparam logic [CFG_W-1:0] RESET_HOLD_RST    = 16'd10000;
	localparam logic [CFG_W-1:0] MENU_HOLD_RST     = 16'd6000;

	localparam logic [CODE_W-1:0] KEY_NONE = 6'd0;
	localparam logic [CODE_W-1:0] KEY_STAR = 6'd42;
	localparam logic [CODE_W-1:0] KEY_HASH = 6'd35;
	localparam logic [CODE_W-1:0] KEY_ZERO = 6'd11;

	localparam logic [KIND_W-1:0] KIND_NEW    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RESET  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MENU   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SERIAL = 2'd3;

	typedef enum logic [3:0] {
		PH_SCAN         = 4'd0,
		PH_DECODE       = 4'd1,
		PH_CONFIRM      = 4'd2,
		PH_CLASSIFY     = 4'd3,
		PH_WAIT_ACK     = 4'd4,
		PH_WAIT_RELEASE = 4'd5,
		PH_RELEASE_DEB  = 4'd6,
		PH_HASH_START   = 4'd7,
		PH_HASH_HELD    = 4'd8,
		PH_HASH_REL     = 4'd9,
		PH_HASH_DONE    = 4'd10,
		PH_STAR_START   = 4'd11,
		PH_STAR_HELD    = 4'd12,
		PH_STAR_REL     = 4'd13,
		PH_STAR_DONE    = 4'd14,
		PH_FINISH       = 4'd15
	} kpd_phase_t;

	typedef struct packed {
		logic             command;
		logic [COLS-1:0]  column_lines;
	} kpd_in_t;

	typedef struct packed {
		logic [ROWS-1:0]   row_drive;
		logic              key_ready;
		logic [CODE_W-1:0] key_code;
		logic [KIND_W-1:0] key_kind;
	} kpd_out_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  index;
		logic [CFG_W-1:0]  data;
	} kpd_cfg_wr_t;

	// Column code 0 means no column and maps to no key.
	function automatic logic [CODE_W-1:0] key_lookup(input logic [ROW_W-1:0] row,
		input logic [COL_W-1:0] col);
		logic [CODE_W-1:0] k;
		k = KEY_NONE;
		unique case ({row, col})
			4'b00_01: k = 6'd1;
			4'b00_10: k = 6'd2;
			4'b00_11: k = 6'd3;
			4'b01_01: k = 6'd4;
			4'b01_10: k = 6'd5;
			4'b01_11: k = 6'd6;
			4'b10_01: k = 6'd7;
			4'b10_10: k = 6'd8;
			4'b10_11: k = 6'd9;
			4'b11_01: k = KEY_STAR;
			4'b11_10: k = KEY_ZERO;
			4'b11_11: k = KEY_HASH;
			default:  k = KEY_NONE;
		endcase
		return k;
	endfunction

endpackage

### rtl/kpd_core.sv
module kpd_core #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kpd_pkg::kpd_cfg_wr_t cfg_wr,
	input  logic              item_accept,
	input  kpd_pkg::kpd_in_t  item,
	output kpd_pkg::kpd_out_t result
);
	import kpd_pkg::*;

	localparam int unsigned CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	logic [CFG_W-1:0]      scan_period_q, debounce_time_q, reset_hold_q, menu_hold_q;
	kpd_phase_t            phase_q, phase_d;
	logic [ROW_W-1:0]      row_q, row_d;
	logic [COL_W-1:0]      col_q, col_d;
	logic [CODE_W-1:0]     key_q, key_d;
	logic [KIND_W-1:0]     kind_q, kind_d;
	logic                  ready_q, ready_d;
	logic [TIMER_BITS-1:0] deb_q, deb_d, deb_inc;
	logic [TIMER_BITS-1:0] hold_q, hold_d, hold_inc;
	logic                  is_tick, pressed;
	logic                  scan_due, deb_over, deb_reached, reset_over, menu_over;
	logic [COL_W-1:0]      first_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q   <= SCAN_PERIOD_RST;
			debounce_time_q <= DEBOUNCE_TIME_RST;
			reset_hold_q    <= RESET_HOLD_RST;
			menu_hold_q     <= MENU_HOLD_RST;
		end else if (cfg_wr.we) begin
			unique case (cfg_wr.index)
				REG_SCAN_PERIOD:   scan_period_q   <= cfg_wr.data;
				REG_DEBOUNCE_TIME: debounce_time_q <= cfg_wr.data;
				REG_RESET_HOLD:    reset_hold_q    <= cfg_wr.data;
				REG_MENU_HOLD:     menu_hold_q     <= cfg_wr.data;
			endcase
		end
	end

	assign is_tick  = item_accept && (item.command == CMD_TICK);
	assign pressed  = (item.column_lines != {COLS{1'b1}});
	assign deb_inc  = (deb_q == {TIMER_BITS{1'b1}}) ? deb_q : deb_q + 1'b1;
	assign hold_inc = (hold_q == {TIMER_BITS{1'b1}}) ? hold_q : hold_q + 1'b1;

	assign scan_due    = CW'(deb_inc) > CW'(scan_period_q);
	assign deb_over    = CW'(deb_inc) > CW'(debounce_time_q);
	assign deb_reached = CW'(deb_inc) >= CW'(debounce_time_q);
	assign reset_over  = CW'(hold_inc) > CW'(reset_hold_q);
	assign menu_over   = CW'(hold_inc) > CW'(menu_hold_q);

	// First low column wins.
	always_comb begin
		priority if (!item.column_lines[0]) first_col = 2'd1;
		else if (!item.column_lines[1])     first_col = 2'd2;
		else                                first_col = 2'd3;
	end

	// Next phase
	always_comb begin
		phase_d = phase_q;
		if (is_tick) begin
			unique case (phase_q)
				PH_SCAN:         if (pressed) phase_d = PH_DECODE;
				PH_DECODE:       phase_d = PH_CONFIRM;
				PH_CONFIRM: begin
					if (!pressed)
						phase_d = PH_SCAN;
					else if (deb_over)
						phase_d = PH_CLASSIFY;
				end
				PH_CLASSIFY: begin
					priority if (key_q == KEY_HASH) phase_d = PH_HASH_START;
					else if (key_q == KEY_STAR)     phase_d = PH_STAR_START;
					else                            phase_d = PH_WAIT_ACK;
				end
				PH_WAIT_ACK:     if (!ready_q) phase_d = PH_WAIT_RELEASE;
				PH_WAIT_RELEASE: if (!pressed) phase_d = PH_RELEASE_DEB;
				PH_RELEASE_DEB:  if (deb_over) phase_d = PH_SCAN;
				PH_HASH_START:   phase_d = PH_HASH_HELD;
				PH_STAR_START:   phase_d = PH_STAR_HELD;
				PH_HASH_HELD:    if (!pressed) phase_d = PH_HASH_REL;
				PH_STAR_HELD:    if (!pressed) phase_d = PH_STAR_REL;
				PH_HASH_REL:     if (deb_reached) phase_d = pressed ? PH_HASH_HELD : PH_HASH_DONE;
				PH_STAR_REL:     if (deb_reached) phase_d = pressed ? PH_STAR_HELD : PH_STAR_DONE;
				PH_HASH_DONE:    phase_d = PH_FINISH;
				PH_STAR_DONE:    phase_d = PH_FINISH;
				PH_FINISH:       phase_d = PH_SCAN;
			endcase
		end
	end

	// Datapath updates per phase
	always_comb begin
		row_d   = row_q;
		col_d   = col_q;
		key_d   = key_q;
		kind_d  = kind_q;
		ready_d = ready_q;
		deb_d   = deb_q;
		hold_d  = hold_q;
		if (item_accept && (item.command == CMD_ACK)) begin
			ready_d = 1'b0;
		end else if (is_tick) begin
			deb_d  = deb_inc;
			hold_d = hold_inc;
			unique case (phase_q)
				PH_SCAN: begin
					if (pressed) begin
						col_d = first_col;
						deb_d = '0;
					end else if (scan_due) begin
						row_d = row_q + 1'b1;
						deb_d = '0;
					end
				end
				PH_DECODE: key_d = key_lookup(row_q, col_q);
				PH_CONFIRM: begin
					if (!pressed) begin
						row_d = '0;
						deb_d = '0;
					end
				end
				PH_CLASSIFY: begin
					if (key_q != KEY_HASH && key_q != KEY_STAR) begin
						kind_d  = KIND_NEW;
						ready_d = 1'b1;
					end
				end
				PH_WAIT_RELEASE, PH_HASH_HELD, PH_STAR_HELD: begin
					if (!pressed)
						deb_d = '0;
				end
				PH_RELEASE_DEB: begin
					if (deb_over) begin
						row_d = '0;
						deb_d = '0;
					end
				end
				PH_HASH_START, PH_STAR_START: begin
					deb_d  = '0;
					hold_d = '0;
				end
				PH_HASH_DONE: kind_d = reset_over ? KIND_RESET : KIND_NEW;
				PH_STAR_DONE: kind_d = menu_over ? KIND_SERIAL : KIND_MENU;
				PH_FINISH: begin
					ready_d = 1'b1;
					row_d   = '0;
					deb_d   = '0;
				end
				PH_WAIT_ACK, PH_HASH_REL, PH_STAR_REL: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SCAN;
			row_q   <= '0;
			col_q   <= '0;
			key_q   <= '0;
			kind_q  <= '0;
			ready_q <= 1'b0;
			deb_q   <= '0;
			hold_q  <= '0;
		end else begin
			phase_q <= phase_d;
			row_q   <= row_d;
			col_q   <= col_d;
			key_q   <= key_d;
			kind_q  <= kind_d;
			ready_q <= ready_d;
			deb_q   <= deb_d;
			hold_q  <= hold_d;
		end
	end

	assign result.row_drive = ~(ROWS'(1) << row_d);
	assign result.key_ready = ready_d;
	assign result.key_code  = key_d;
	assign result.key_kind  = kind_d;

endmodule

### rtl/kpd_out_buf.sv
module kpd_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  kpd_pkg::kpd_out_t push_data,
	output logic              full,
	output logic              out_valid,
	input  logic              out_stall,
	output kpd_pkg::kpd_out_t out_data
);
	import kpd_pkg::*;

	kpd_out_t   ent0_q, ent1_q;
	logic [1:0] count_q;
	logic       pop;

	assign out_valid = (count_q != 2'd0);
	assign full      = (count_q == 2'd2);
	assign pop       = out_valid && !out_stall;
	assign out_data  = ent0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
	end

	// Head entry always sits in ent0; advance ent1 on a pop.
	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (count_q == 2'd0)
					ent0_q <= push_data;
				else
					ent1_q <= push_data;
			end
			2'b01: ent0_q <= ent1_q;
			2'b11: begin
				if (count_q == 2'd1)
					ent0_q <= push_data;
				else begin
					ent0_q <= ent1_q;
					ent1_q <= push_data;
				end
			end
			2'b00: ;
		endcase
	end

endmodule

### rtl/keypad_scan_debounce_hold_top.sv
// Channel   Handshake             Payload
// in        in_valid / in_stall   in_data   (command, column_lines)
// out       out_valid / out_stall out_data  (row_drive, key_ready, key_code, key_kind)
// cfg       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle while in_stall is low: the state update and the result both
// settle in the cycle of the transfer, and the result queues in the buffer for out.
// A two-entry result buffer decouples the sides; in_stall rises only when it is full.
// Reset clears the phase, timers and buffer and loads the register defaults.
// cfg_ready is always high; registers take effect on the next item.
module keypad_scan_debounce_hold_top #(
	parameter int unsigned TIMER_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  kpd_pkg::kpd_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output kpd_pkg::kpd_out_t             out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kpd_pkg::IDX_W-1:0]     cfg_index,
	input  logic [kpd_pkg::CFG_W-1:0]     cfg_data
);
	import kpd_pkg::*;

	logic        buf_full, accept;
	kpd_out_t    result;
	kpd_cfg_wr_t cfg_wr;

	assign cfg_ready    = 1'b1;
	assign cfg_wr.we    = cfg_valid && cfg_ready;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	assign in_stall = buf_full;
	assign accept   = in_valid && !in_stall;

	kpd_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg_wr),
		.item_accept (accept),
		.item        (in_data),
		.result      (result)
	);

	kpd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### rtl/kpd_checker.sv
module kpd_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input kpd_pkg::kpd_out_t out_data
);
	import kpd_pkg::*;

	// Held result must not move while the sink stalls.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed under stall");

	a_stall_needs_backlog: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && $past(out_valid))
		else $error("input stalled with no results pending");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(in_valid && !in_stall) && !$past(out_valid) |-> out_valid)
		else $error("transfer gave no result");

	a_one_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot(~out_data.row_drive))
		else $error("row drive not a single low bit");

	a_legal_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.key_code <= 6'd9) || (out_data.key_code == KEY_ZERO) ||
			(out_data.key_code == KEY_STAR) || (out_data.key_code == KEY_HASH))
		else $error("illegal key code");

endmodule

bind keypad_scan_debounce_hold_top kpd_checker u_kpd_checker (.*);
